// File: design/power_fault_supervisor_defines.svh
// Assertion macros for the power fault supervisor.
// Used by modules that check their own control state; expects a clock named clock.
`ifndef POWER_FAULT_SUPERVISOR_DEFINES_SVH
`define POWER_FAULT_SUPERVISOR_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define PFS_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pfs assertion failed");

// Next-cycle implication, disabled during reset.
`define PFS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pfs assertion failed");

`endif

// File: design/pfs_pkg.sv
// Shared types and codes for the power fault supervisor.
// No dependencies.
package pfs_pkg;

   localparam int MV_W = 20;
   localparam int MA_W = 20;
   localparam int MS_W = 32;
   localparam int PW_W = 32;
   localparam int CSR_DATA_W = 32;
   localparam int CSR_ADDR_W = 5;

   localparam logic [1:0] MODE_NORMAL   = 2'd0;
   localparam logic [1:0] MODE_WARNING  = 2'd1;
   localparam logic [1:0] MODE_FAULT    = 2'd2;
   localparam logic [1:0] MODE_RECOVERY = 2'd3;

   localparam logic [1:0] CODE_NONE        = 2'd0;
   localparam logic [1:0] CODE_INVALID     = 2'd1;
   localparam logic [1:0] CODE_OVERCURRENT = 2'd2;
   localparam logic [1:0] CODE_VOLTAGE     = 2'd3;

   localparam logic [2:0] REG_OC_WARN    = 3'd0;
   localparam logic [2:0] REG_OC_FAULT   = 3'd1;
   localparam logic [2:0] REG_V_CUTOFF   = 3'd2;
   localparam logic [2:0] REG_V_LOW      = 3'd3;
   localparam logic [2:0] REG_V_HIGH     = 3'd4;
   localparam logic [2:0] REG_DEBOUNCE   = 3'd5;
   localparam logic [2:0] REG_RECOVERY   = 3'd6;

   typedef struct packed {
      logic [MA_W-1:0] overcurrent_warn_ma;
      logic [MA_W-1:0] overcurrent_fault_ma;
      logic [MV_W-1:0] voltage_cutoff_mv;
      logic [MV_W-1:0] voltage_low_mv;
      logic [MV_W-1:0] voltage_high_mv;
      logic [MS_W-1:0] debounce_ms;
      logic [MS_W-1:0] recovery_ms;
   } cfg_type;

   typedef struct packed {
      logic                   sample_valid;
      logic [MV_W-1:0]        voltage_mv;
      logic [MA_W-1:0]        current_ma;
      logic signed [PW_W-1:0] power_mw;
      logic [MS_W-1:0]        now_ms;
   } sample_type;

   typedef struct packed {
      logic [1:0]             fault_code;
      logic [1:0]             system_state;
      logic [MS_W-1:0]        faults_seen;
      logic [MS_W-1:0]        stamp_ms;
      logic [MV_W-1:0]        voltage_out_mv;
      logic [MA_W-1:0]        current_out_ma;
      logic signed [PW_W-1:0] power_out_mw;
   } result_type;

endpackage

// File: design/pfs_req_if.sv
// Sample channel into the supervisor: valid/ready plus sample fields.
// Depends on pfs_pkg.
interface pfs_req_if import pfs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic                   sample_valid;
   logic [MV_W-1:0]        voltage_mv;
   logic [MA_W-1:0]        current_ma;
   logic signed [PW_W-1:0] power_mw;
   logic [MS_W-1:0]        now_ms;

   modport source (output valid, sample_valid, voltage_mv, current_ma, power_mw, now_ms,
                   input ready);
   modport sink   (input valid, sample_valid, voltage_mv, current_ma, power_mw, now_ms,
                   output ready);
endinterface

// File: design/pfs_rsp_if.sv
// Result channel out of the supervisor: valid/ready plus result fields.
// Depends on pfs_pkg.
interface pfs_rsp_if import pfs_pkg::*; ();
   logic                   valid;
   logic                   ready;
   logic [1:0]             fault_code;
   logic [1:0]             system_state;
   logic [MS_W-1:0]        faults_seen;
   logic [MS_W-1:0]        stamp_ms;
   logic [MV_W-1:0]        voltage_out_mv;
   logic [MA_W-1:0]        current_out_ma;
   logic signed [PW_W-1:0] power_out_mw;

   modport source (output valid, fault_code, system_state, faults_seen, stamp_ms,
                   voltage_out_mv, current_out_ma, power_out_mw, input ready);
   modport sink   (input valid, fault_code, system_state, faults_seen, stamp_ms,
                   voltage_out_mv, current_out_ma, power_out_mw, output ready);
endinterface

// File: design/power_fault_supervisor.sv
// Power fault supervisor: samples in on req, one result per sample out on rsp.
//
// Usage:
//   req carries one sensor sample per item (valid flag, voltage, current,
//   power, ms timestamp); rsp returns one item per sample with the fault code,
//   supervisor state, fault entry count and the echoed sample fields.
//   Thresholds and timers are set over the csr_ APB port, and reads return
//   the register values; the user is to write them only while no sample is
//   in flight, which the block itself does not enforce. A sample passes the
//   input register, then the classifier and state update feed the result
//   register, which drives rsp valid. Throughput is one item per cycle
//   while rsp.ready stays high. When rsp.ready is low the result register
//   holds; the input register still takes one more item, after which
//   req.ready drops until rsp drains.
//   Synchronous reset empties both stages, restores register defaults and
//   puts the state machine in normal with a zero fault count.
// Depends on pfs_pkg, pfs_req_if, pfs_rsp_if, pfs_csr and pfs_core.
module power_fault_supervisor import pfs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   pfs_req_if.sink               req,
   pfs_rsp_if.source             rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready
);

   cfg_type cfg;

   pfs_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   pfs_core u_core (
      .clock (clock),
      .reset (reset),
      .cfg   (cfg),
      .req   (req),
      .rsp   (rsp)
   );

endmodule

// File: design/pfs_csr.sv
// APB-style configuration registers for the supervisor thresholds and timers.
// Depends on pfs_pkg.
module pfs_csr import pfs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   output logic [CSR_DATA_W-1:0] csr_prdata,
   output logic                  csr_pready,
   output cfg_type               cfg
);

   cfg_type    cfg_ff;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite;
   assign reg_idx    = csr_paddr[CSR_ADDR_W-1:2];
   assign cfg        = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.overcurrent_warn_ma  <= MA_W'(15000);
         cfg_ff.overcurrent_fault_ma <= MA_W'(20000);
         cfg_ff.voltage_cutoff_mv    <= MV_W'(180000);
         cfg_ff.voltage_low_mv       <= MV_W'(200000);
         cfg_ff.voltage_high_mv      <= MV_W'(250000);
         cfg_ff.debounce_ms          <= MS_W'(100);
         cfg_ff.recovery_ms          <= MS_W'(5000);
      end else if (wr_en) begin
         case (reg_idx)
            REG_OC_WARN:  cfg_ff.overcurrent_warn_ma  <= csr_pwdata[MA_W-1:0];
            REG_OC_FAULT: cfg_ff.overcurrent_fault_ma <= csr_pwdata[MA_W-1:0];
            REG_V_CUTOFF: cfg_ff.voltage_cutoff_mv    <= csr_pwdata[MV_W-1:0];
            REG_V_LOW:    cfg_ff.voltage_low_mv       <= csr_pwdata[MV_W-1:0];
            REG_V_HIGH:   cfg_ff.voltage_high_mv      <= csr_pwdata[MV_W-1:0];
            REG_DEBOUNCE: cfg_ff.debounce_ms          <= csr_pwdata[MS_W-1:0];
            REG_RECOVERY: cfg_ff.recovery_ms          <= csr_pwdata[MS_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_idx)
         REG_OC_WARN:  csr_prdata = CSR_DATA_W'(cfg_ff.overcurrent_warn_ma);
         REG_OC_FAULT: csr_prdata = CSR_DATA_W'(cfg_ff.overcurrent_fault_ma);
         REG_V_CUTOFF: csr_prdata = CSR_DATA_W'(cfg_ff.voltage_cutoff_mv);
         REG_V_LOW:    csr_prdata = CSR_DATA_W'(cfg_ff.voltage_low_mv);
         REG_V_HIGH:   csr_prdata = CSR_DATA_W'(cfg_ff.voltage_high_mv);
         REG_DEBOUNCE: csr_prdata = CSR_DATA_W'(cfg_ff.debounce_ms);
         REG_RECOVERY: csr_prdata = CSR_DATA_W'(cfg_ff.recovery_ms);
         default:      csr_prdata = '0;
      endcase
   end

endmodule

// File: design/pfs_core.sv
// Supervisor datapath: input register, classify + state machine, result register.
// Depends on pfs_pkg, pfs_req_if, pfs_rsp_if and the assertion macro header.
`include "power_fault_supervisor_defines.svh"

module pfs_core import pfs_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   pfs_req_if.sink     req,
   pfs_rsp_if.source   rsp
);

   logic            in_valid_ff;
   sample_type      in_ff;
   logic            out_valid_ff;
   result_type      out_ff;
   logic            adv;

   logic [1:0]      mode_ff, mode_in;
   logic [1:0]      held_ff, held_in;
   logic            abn_flag_ff, abn_flag_in;
   logic [MS_W-1:0] abn_start_ff, abn_start_in;
   logic            heal_flag_ff, heal_flag_in;
   logic [MS_W-1:0] heal_start_ff, heal_start_in;
   logic [MS_W-1:0] entries_ff, entries_in;

   logic [1:0]      cls;
   logic            serious;
   logic [MS_W-1:0] abn_base, abn_elapsed, heal_elapsed;

   // two-stage pipe, ready chains back combinationally
   assign adv       = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req.ready) begin
            in_valid_ff <= req.valid;
         end
         if (adv) begin
            out_valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.valid && req.ready) begin
         in_ff.sample_valid <= req.sample_valid;
         in_ff.voltage_mv   <= req.voltage_mv;
         in_ff.current_ma   <= req.current_ma;
         in_ff.power_mw     <= req.power_mw;
         in_ff.now_ms       <= req.now_ms;
      end
   end

   always_comb begin
      if (!in_ff.sample_valid) begin
         cls = CODE_INVALID;
      end else if (in_ff.current_ma >= cfg.overcurrent_warn_ma) begin
         cls = CODE_OVERCURRENT;
      end else if (in_ff.voltage_mv < cfg.voltage_cutoff_mv ||
                   in_ff.voltage_mv < cfg.voltage_low_mv ||
                   in_ff.voltage_mv > cfg.voltage_high_mv) begin
         cls = CODE_VOLTAGE;
      end else begin
         cls = CODE_NONE;
      end
   end

   assign serious      = (cls == CODE_OVERCURRENT) || !in_ff.sample_valid ||
                         (in_ff.current_ma >= cfg.overcurrent_fault_ma);
   assign abn_base     = abn_flag_ff ? abn_start_ff : in_ff.now_ms;
   assign abn_elapsed  = in_ff.now_ms - abn_base;
   assign heal_elapsed = in_ff.now_ms - heal_start_ff;

   always_comb begin
      mode_in       = mode_ff;
      held_in       = held_ff;
      abn_flag_in   = abn_flag_ff;
      abn_start_in  = abn_start_ff;
      heal_flag_in  = heal_flag_ff;
      heal_start_in = heal_start_ff;
      entries_in    = entries_ff;
      if (cls != CODE_NONE) begin
         heal_flag_in  = 1'b0;
         heal_start_in = '0;
         abn_flag_in   = 1'b1;
         abn_start_in  = abn_base;
         if (serious && abn_elapsed >= cfg.debounce_ms) begin
            if (mode_ff != MODE_FAULT) begin
               entries_in = entries_ff + MS_W'(1);
            end
            mode_in = MODE_FAULT;
            held_in = cls;
         end else if (mode_ff == MODE_NORMAL || mode_ff == MODE_RECOVERY) begin
            mode_in = MODE_WARNING;
            held_in = cls;
         end
      end else begin
         abn_flag_in  = 1'b0;
         abn_start_in = '0;
         if (mode_ff == MODE_FAULT || mode_ff == MODE_WARNING) begin
            mode_in       = MODE_RECOVERY;
            held_in       = CODE_NONE;
            heal_start_in = in_ff.now_ms;
            heal_flag_in  = 1'b1;
         end else if (mode_ff == MODE_RECOVERY && heal_flag_ff &&
                      heal_elapsed >= cfg.recovery_ms) begin
            mode_in      = MODE_NORMAL;
            heal_flag_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_NORMAL;
         held_ff       <= CODE_NONE;
         abn_flag_ff   <= 1'b0;
         abn_start_ff  <= '0;
         heal_flag_ff  <= 1'b0;
         heal_start_ff <= '0;
         entries_ff    <= '0;
      end else if (adv) begin
         mode_ff       <= mode_in;
         held_ff       <= held_in;
         abn_flag_ff   <= abn_flag_in;
         abn_start_ff  <= abn_start_in;
         heal_flag_ff  <= heal_flag_in;
         heal_start_ff <= heal_start_in;
         entries_ff    <= entries_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         out_ff.fault_code     <= held_in;
         out_ff.system_state   <= mode_in;
         out_ff.faults_seen    <= entries_in;
         out_ff.stamp_ms       <= in_ff.now_ms;
         out_ff.voltage_out_mv <= in_ff.voltage_mv;
         out_ff.current_out_ma <= in_ff.current_ma;
         out_ff.power_out_mw   <= in_ff.power_mw;
      end
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.fault_code     = out_ff.fault_code;
   assign rsp.system_state   = out_ff.system_state;
   assign rsp.faults_seen    = out_ff.faults_seen;
   assign rsp.stamp_ms       = out_ff.stamp_ms;
   assign rsp.voltage_out_mv = out_ff.voltage_out_mv;
   assign rsp.current_out_ma = out_ff.current_out_ma;
   assign rsp.power_out_mw   = out_ff.power_out_mw;

   `PFS_ASSERT_NOW(a_held_none_when_calm,
      mode_ff == MODE_NORMAL || mode_ff == MODE_RECOVERY, held_ff == CODE_NONE)
   `PFS_ASSERT_NOW(a_held_set_when_alarmed,
      mode_ff == MODE_WARNING || mode_ff == MODE_FAULT, held_ff != CODE_NONE)
   `PFS_ASSERT_NOW(a_heal_only_in_recovery, heal_flag_ff, mode_ff == MODE_RECOVERY)
   `PFS_ASSERT_NOW(a_abn_only_when_alarmed, abn_flag_ff,
      mode_ff == MODE_WARNING || mode_ff == MODE_FAULT)
   `PFS_ASSERT_NOW(a_count_on_fault_entry, !$past(reset) && !$stable(entries_ff),
      mode_ff == MODE_FAULT && $past(mode_ff) != MODE_FAULT)

endmodule

// File: dv/supervisor_check_pkg.sv
`timescale 1ns / 100ps
// Result tracker for the power fault supervisor testbench: mirrors the state
// machine and limits, queues the expected result of each sample, checks results.
// Depends on pfs_pkg.
package supervisor_check_pkg;
   import pfs_pkg::*;

   class supervisor_tracker_type;
      cfg_type     limits;
      logic [1:0]  mode;
      logic [1:0]  held_code;
      bit          abnormal_on;
      bit          healthy_on;
      logic [31:0] abnormal_since;
      logic [31:0] healthy_since;
      logic [31:0] entries;
      result_type  pending_reports[$];
      int          mismatches;
      int          reports_seen;

      function new();
         limits.overcurrent_warn_ma  = 15000;
         limits.overcurrent_fault_ma = 20000;
         limits.voltage_cutoff_mv    = 180000;
         limits.voltage_low_mv       = 200000;
         limits.voltage_high_mv      = 250000;
         limits.debounce_ms          = 100;
         limits.recovery_ms          = 5000;
         mode           = MODE_NORMAL;
         held_code      = CODE_NONE;
         abnormal_on    = 1'b0;
         healthy_on     = 1'b0;
         abnormal_since = '0;
         healthy_since  = '0;
         entries        = '0;
         mismatches     = 0;
         reports_seen   = 0;
      endfunction

      function void write_limit(logic [2:0] index, logic [31:0] value);
         case (index)
            REG_OC_WARN:  limits.overcurrent_warn_ma  = value[MA_W-1:0];
            REG_OC_FAULT: limits.overcurrent_fault_ma = value[MA_W-1:0];
            REG_V_CUTOFF: limits.voltage_cutoff_mv    = value[MV_W-1:0];
            REG_V_LOW:    limits.voltage_low_mv       = value[MV_W-1:0];
            REG_V_HIGH:   limits.voltage_high_mv      = value[MV_W-1:0];
            REG_DEBOUNCE: limits.debounce_ms          = value[MS_W-1:0];
            REG_RECOVERY: limits.recovery_ms          = value[MS_W-1:0];
            default: ;
         endcase
      endfunction

      function void note_sample(sample_type s);
         logic [1:0]  cls;
         logic [31:0] elapsed;
         bit          serious;
         result_type  r;
         if (!s.sample_valid)
            cls = CODE_INVALID;
         else if (s.current_ma >= limits.overcurrent_warn_ma)
            cls = CODE_OVERCURRENT;
         else if (s.voltage_mv < limits.voltage_cutoff_mv ||
                  s.voltage_mv < limits.voltage_low_mv ||
                  s.voltage_mv > limits.voltage_high_mv)
            cls = CODE_VOLTAGE;
         else
            cls = CODE_NONE;

         if (cls != CODE_NONE) begin
            serious = cls == CODE_OVERCURRENT || !s.sample_valid ||
                      s.current_ma >= limits.overcurrent_fault_ma;
            healthy_on    = 1'b0;
            healthy_since = '0;
            if (!abnormal_on) begin
               abnormal_since = s.now_ms;
               abnormal_on    = 1'b1;
            end
            elapsed = s.now_ms - abnormal_since;
            if (serious && elapsed >= limits.debounce_ms) begin
               if (mode != MODE_FAULT) entries = entries + 1;
               mode      = MODE_FAULT;
               held_code = cls;
            end else if (mode == MODE_NORMAL || mode == MODE_RECOVERY) begin
               mode      = MODE_WARNING;
               held_code = cls;
            end
         end else begin
            abnormal_on    = 1'b0;
            abnormal_since = '0;
            elapsed = s.now_ms - healthy_since;
            if (mode == MODE_FAULT || mode == MODE_WARNING) begin
               mode          = MODE_RECOVERY;
               held_code     = CODE_NONE;
               healthy_since = s.now_ms;
               healthy_on    = 1'b1;
            end else if (mode == MODE_RECOVERY && healthy_on &&
                         elapsed >= limits.recovery_ms) begin
               mode       = MODE_NORMAL;
               healthy_on = 1'b0;
            end
         end

         r.fault_code     = held_code;
         r.system_state   = mode;
         r.faults_seen    = entries;
         r.stamp_ms       = s.now_ms;
         r.voltage_out_mv = s.voltage_mv;
         r.current_out_ma = s.current_ma;
         r.power_out_mw   = s.power_mw;
         pending_reports.push_back(r);
      endfunction

      function void field_check(string name, logic [31:0] want, logic [31:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_result(result_type got);
         result_type want;
         reports_seen++;
         if (pending_reports.size() == 0) begin
            $display("%0t: result with nothing expected, expected none, actual %h",
                     $time, got);
            mismatches++;
            return;
         end
         want = pending_reports.pop_front();
         field_check("fault_code", 32'(want.fault_code), 32'(got.fault_code));
         field_check("system_state", 32'(want.system_state), 32'(got.system_state));
         field_check("faults_seen", want.faults_seen, got.faults_seen);
         field_check("stamp_ms", want.stamp_ms, got.stamp_ms);
         field_check("voltage_out_mv", 32'(want.voltage_out_mv),
                     32'(got.voltage_out_mv));
         field_check("current_out_ma", 32'(want.current_out_ma),
                     32'(got.current_out_ma));
         field_check("power_out_mw", want.power_out_mw, got.power_out_mw);
      endfunction
   endclass

endpackage

// File: dv/testbench.sv
`timescale 1ns / 100ps
// Top-level testbench for power_fault_supervisor: directed and random sensor
// samples with random idling on both channels, results checked by the tracker.
// Depends on pfs_pkg, pfs_req_if, pfs_rsp_if, supervisor_check_pkg and the design.
module testbench;
   import pfs_pkg::*;
   import supervisor_check_pkg::*;

   typedef enum int {SK_HEALTHY, SK_INVALID, SK_OVERCURRENT, SK_VOLTAGE, SK_NOISE}
      sample_kind_type;

   localparam logic [2:0] REG_SPARE = 3'd7;
   localparam int ITEMS_PER_PHASE = 130;
   localparam int HOLD_AT         = 120;
   localparam int HOLD_CYCLES     = 80;

   logic                  clock;
   logic                  reset;
   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   bit                     calm;
   int                     items_sent;
   logic [31:0]            clock_ms;
   supervisor_tracker_type tracker;

   pfs_req_if req_ch();
   pfs_rsp_if rsp_ch();

   power_fault_supervisor dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_ch),
      .rsp         (rsp_ch),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2000000;
      $display("TB_ERROR");
      $finish;
   end

   function automatic int idle_len();
      int r;
      r = $urandom_range(99);
      if (calm || r < 55) return 0;
      if (r < 90) return $urandom_range(3, 1);
      return $urandom_range(30, 6);
   endfunction

   function automatic logic [31:0] time_step();
      logic [31:0] deb;
      logic [31:0] rec;
      int          r;
      deb = tracker.limits.debounce_ms;
      rec = tracker.limits.recovery_ms;
      r = $urandom_range(99);
      if (r < 10) return 0;
      if (r < 50) return $urandom_range((deb >> 2) + 1, 0);
      if (r < 70) return deb + $urandom_range(2) - 1;
      if (r < 95) return $urandom_range((rec >> 1) + 1, 0) + (rec >> 1);
      return $urandom;
   endfunction

   function automatic sample_type reading(bit ok, logic [19:0] v, logic [19:0] i,
                                          logic [31:0] p, logic [31:0] t);
      sample_type s;
      s.sample_valid = ok;
      s.voltage_mv   = v;
      s.current_ma   = i;
      s.power_mw     = p;
      s.now_ms       = t;
      return s;
   endfunction

   function automatic sample_type pick_reading(sample_kind_type kind, logic [31:0] t);
      logic [19:0] warn;
      logic [19:0] lo;
      logic [19:0] hi;
      logic [19:0] v;
      logic [19:0] i;
      bit          ok;
      warn = tracker.limits.overcurrent_warn_ma;
      lo = (tracker.limits.voltage_cutoff_mv > tracker.limits.voltage_low_mv) ?
           tracker.limits.voltage_cutoff_mv : tracker.limits.voltage_low_mv;
      hi = tracker.limits.voltage_high_mv;
      v  = 20'($urandom);
      i  = 20'($urandom);
      ok = 1'b1;
      case (kind)
         SK_HEALTHY: begin
            v = (lo <= hi) ? 20'($urandom_range(hi, lo)) : lo;
            i = (warn != 0) ? 20'($urandom_range(warn - 1, 0)) : 20'd0;
         end
         SK_OVERCURRENT: i = 20'($urandom_range(20'hFFFFF, warn));
         SK_VOLTAGE: begin
            i = (warn != 0) ? 20'($urandom_range(warn - 1, 0)) : 20'd0;
            if (hi != 20'hFFFFF && (lo == 0 || $urandom_range(1) == 1))
               v = 20'($urandom_range(20'hFFFFF, hi + 1));
            else if (lo != 0)
               v = 20'($urandom_range(lo - 1, 0));
         end
         SK_INVALID: ok = 1'b0;
         default: ok = 1'($urandom_range(1));
      endcase
      return reading(ok, v, i, $urandom, t);
   endfunction

   task automatic csr_write(input logic [2:0] index, input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      tracker.write_limit(index, value);
      @(posedge clock);
   endtask

   task automatic apply_limits(input logic [31:0] warn, input logic [31:0] fault,
                               input logic [31:0] cutoff, input logic [31:0] low,
                               input logic [31:0] high, input logic [31:0] deb,
                               input logic [31:0] rec);
      csr_write(REG_OC_WARN, warn);
      csr_write(REG_OC_FAULT, fault);
      csr_write(REG_V_CUTOFF, cutoff);
      csr_write(REG_V_LOW, low);
      csr_write(REG_V_HIGH, high);
      csr_write(REG_DEBOUNCE, deb);
      csr_write(REG_RECOVERY, rec);
   endtask

   task automatic send_reading(input sample_type s);
      int gap;
      gap = idle_len();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.sample_valid <= s.sample_valid;
      req_ch.voltage_mv   <= s.voltage_mv;
      req_ch.current_ma   <= s.current_ma;
      req_ch.power_mw     <= s.power_mw;
      req_ch.now_ms       <= s.now_ms;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      tracker.note_sample(s);
      items_sent++;
   endtask

   task automatic settle();
      req_ch.valid <= 1'b0;
      while (tracker.pending_reports.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // fault run of one or a few classes, then usually a healthy run; some noise
   task automatic run_episode();
      int              faults;
      int              mends;
      sample_kind_type kind;
      if ($urandom_range(99) < 15) begin
         clock_ms += time_step();
         send_reading(pick_reading(SK_NOISE, clock_ms));
         return;
      end
      kind   = sample_kind_type'($urandom_range(SK_VOLTAGE, SK_INVALID));
      faults = $urandom_range(8, 1);
      mends  = $urandom_range(6, 0);
      repeat (faults) begin
         clock_ms += time_step();
         send_reading(pick_reading(kind, clock_ms));
         if ($urandom_range(3) == 0)
            kind = sample_kind_type'($urandom_range(SK_VOLTAGE, SK_INVALID));
      end
      repeat (mends) begin
         clock_ms += time_step();
         send_reading(pick_reading(SK_HEALTHY, clock_ms));
      end
   endtask

   task automatic random_phase(input int count);
      int target;
      target   = items_sent + count;
      clock_ms = $urandom;
      while (items_sent < target) run_episode();
      settle();
   endtask

   always @(posedge clock) begin : watch
      result_type got;
      if (reset === 1'b0 && rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1) begin
         got.fault_code     = rsp_ch.fault_code;
         got.system_state   = rsp_ch.system_state;
         got.faults_seen    = rsp_ch.faults_seen;
         got.stamp_ms       = rsp_ch.stamp_ms;
         got.voltage_out_mv = rsp_ch.voltage_out_mv;
         got.current_out_ma = rsp_ch.current_out_ma;
         got.power_out_mw   = rsp_ch.power_out_mw;
         tracker.check_result(got);
      end
   end

   // result side: random stalls, plus one long hold so the block backs up
   initial begin : rsp_side
      bit held;
      held = 1'b0;
      rsp_ch.ready <= 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         if (!held && tracker.reports_seen >= HOLD_AT) begin
            held = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (calm || $urandom_range(99) < 70) begin
            rsp_ch.ready <= 1'b1;
            @(posedge clock);
         end else begin
            rsp_ch.ready <= 1'b0;
            repeat (idle_len() + 1) @(posedge clock);
         end
      end
   end

   initial begin : main
      tracker    = new();
      calm       = 1'b0;
      items_sent = 0;
      clock_ms   = '0;
      reset               <= 1'b1;
      csr_psel            <= 1'b0;
      csr_penable         <= 1'b0;
      csr_pwrite          <= 1'b0;
      csr_paddr           <= '0;
      csr_pwdata          <= '0;
      req_ch.valid        <= 1'b0;
      req_ch.sample_valid <= 1'b0;
      req_ch.voltage_mv   <= '0;
      req_ch.current_ma   <= '0;
      req_ch.power_mw     <= '0;
      req_ch.now_ms       <= '0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset limits: each fault class, boundaries, debounce, recovery, wrap
      send_reading(reading(1, 220000, 1000, 0, 1000));
      send_reading(reading(1, 190000, 1000, 1, 1010));
      send_reading(reading(1, 220000, 1000, 2, 1020));
      send_reading(reading(1, 220000, 1000, 3, 6020));
      send_reading(reading(1, 220000, 15000, 4, 7000));
      send_reading(reading(1, 220000, 15000, 5, 7099));
      send_reading(reading(1, 220000, 20'hFFFFF, 6, 7100));
      send_reading(reading(0, 220000, 0, 7, 7200));
      send_reading(reading(1, 220000, 14999, 8, 7300));
      send_reading(reading(1, 250001, 0, 9, 7310));
      send_reading(reading(1, 0, 19999, 10, 7500));
      send_reading(reading(1, 20'hFFFFF, 14999, 11, 7550));
      send_reading(reading(1, 250000, 14999, 12, 7600));
      send_reading(reading(1, 200000, 0, 13, 8000));
      send_reading(reading(0, 20'hFFFFF, 20'hFFFFF, 32'h8000_0000, 32'hFFFF_FFF0));
      send_reading(reading(0, 0, 0, 32'h7FFF_FFFF, 32'h0000_0060));
      send_reading(reading(1, 230000, 0, 32'hFFFF_FFFF, 32'h0000_0100));
      send_reading(reading(1, 230000, 0, 32'h5555_5555, 32'h0000_1490));
      settle();

      // inconsistent limits: cutoff above low, serious limit below warn limit
      apply_limits(20'hFFFFF, 1000, 210000, 200000, 250000, 0, 0);
      csr_write(REG_SPARE, 32'hFFFF_FFFF);
      send_reading(reading(1, 205000, 5000, 32'hAAAA_AAAA, 100));
      send_reading(reading(1, 230000, 0, 0, 101));
      send_reading(reading(1, 230000, 0, 0, 101));
      send_reading(reading(1, 205000, 999, 0, 102));
      send_reading(reading(0, 230000, 20'hFFFFF, 0, 103));
      send_reading(reading(1, 230000, 20'hFFFFF, 0, 104));
      send_reading(reading(1, 210000, 0, 0, 105));
      settle();

      apply_limits(15000, 20000, 180000, 200000, 250000,
                   $urandom_range(300, 20), $urandom_range(800, 50));
      random_phase(ITEMS_PER_PHASE);

      apply_limits(0, 0, 0, 0, 0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
      random_phase(60);

      calm = 1'b1;
      apply_limits(20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 20'hFFFFF, 0, 0);
      random_phase(80);
      calm = 1'b0;

      apply_limits($urandom, $urandom, $urandom, $urandom, $urandom,
                   $urandom_range(400, 0), $urandom_range(400, 0));
      random_phase(ITEMS_PER_PHASE);

      begin : ordered
         logic [31:0] warn;
         logic [31:0] cutoff;
         logic [31:0] low;
         warn   = $urandom_range(60000, 1000);
         cutoff = $urandom_range(200000, 100000);
         low    = cutoff + $urandom_range(30000, 0);
         apply_limits(warn, warn + $urandom_range(20000, 0) - 5000, cutoff, low,
                      low + $urandom_range(100000, 0), $urandom_range(200, 1),
                      $urandom_range(600, 1));
      end
      random_phase(ITEMS_PER_PHASE);

      repeat (10) @(posedge clock);
      if (tracker.mismatches == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

// File: filelist.f
+incdir+design
design/pfs_pkg.sv
design/pfs_req_if.sv
design/pfs_rsp_if.sv
design/pfs_csr.sv
design/pfs_core.sv
design/power_fault_supervisor.sv
dv/supervisor_check_pkg.sv
dv/testbench.sv
